// File: design/ghacc_pkg.sv
package ghacc_pkg;

	localparam int unsigned BLOCK_W    = 128;
	localparam int unsigned HALF_W     = 64;
	localparam int unsigned COUNT_W    = 5;
	localparam int unsigned IN_DATA_W  = 136;
	localparam int unsigned DIGIT_W    = 8;
	localparam int unsigned NUM_DIGITS = BLOCK_W / DIGIT_W;
	localparam int unsigned CNT_W      = $clog2(NUM_DIGITS);
	localparam int unsigned CFG_IDX_W  = 1;

	localparam logic [7:0]           REDUCE_POLY = 8'hE1;
	localparam logic [COUNT_W-1:0]   FULL_COUNT  = 5'd16;

	localparam logic [CFG_IDX_W-1:0] REG_SUBKEY_HIGH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBKEY_LOW  = 1'b1;

	typedef logic [BLOCK_W-1:0] blk_t;

	typedef struct packed {
		logic start;
		logic absorb;
		blk_t blk;
	} ghacc_entry_t;

	typedef struct packed {
		blk_t z;
		blk_t v;
	} gf_state_t;

	// One digit of the GCM shift-and-add multiply, most significant bit first.
	function automatic gf_state_t gf_digit(input gf_state_t st, input logic [DIGIT_W-1:0] xd);
		gf_state_t r;
		logic      carry;
		r = st;
		for (int i = DIGIT_W - 1; i >= 0; i--) begin
			if (xd[i]) begin
				r.z = r.z ^ r.v;
			end
			carry = r.v[0];
			r.v   = r.v >> 1;
			if (carry) begin
				r.v[BLOCK_W-1 -: 8] = r.v[BLOCK_W-1 -: 8] ^ REDUCE_POLY;
			end
		end
		return r;
	endfunction

endpackage

// File: design/ghacc_front.sv
module ghacc_front (
	input  logic                           start_req,
	input  logic [ghacc_pkg::HALF_W-1:0]   block_high,
	input  logic [ghacc_pkg::HALF_W-1:0]   block_low,
	input  logic [ghacc_pkg::COUNT_W-1:0]  byte_count,
	output ghacc_pkg::ghacc_entry_t        entry
);
	import ghacc_pkg::*;

	logic [COUNT_W-1:0] sat_count;
	logic [7:0]         shamt;
	blk_t               keep_mask;

	always_comb begin
		// counts above a full block saturate
		sat_count    = (byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;
		shamt        = {sat_count, 3'b000};
		keep_mask    = ~({BLOCK_W{1'b1}} >> shamt);
		entry.start  = start_req;
		entry.absorb = (byte_count != '0);
		entry.blk    = {block_high, block_low} & keep_mask;
	end

endmodule

// File: design/ghacc_fifo.sv
module ghacc_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  ghacc_pkg::ghacc_entry_t wr_entry,
	input  logic                    pop,
	output ghacc_pkg::ghacc_entry_t rd_entry,
	output logic                    full,
	output logic                    empty
);
	import ghacc_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	ghacc_entry_t     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	always_comb begin
		full     = (count_q == CNT_W'(DEPTH));
		empty    = (count_q == '0);
		do_push  = push && !full;
		do_pop   = pop && !empty;
		rd_entry = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	as_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
	as_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |=> (count_q == '0) || (count_q == CNT_W'(1)))
		else $error("queue drained below empty");
	as_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers differ while empty");

endmodule

// File: design/ghacc_back.sv
module ghacc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ghacc_pkg::blk_t              subkey,
	input  logic                         q_valid,
	input  ghacc_pkg::ghacc_entry_t      q_entry,
	output logic                         q_pop,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [ghacc_pkg::BLOCK_W-1:0] m_axis_tdata
);
	import ghacc_pkg::*;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	blk_t             y_q;
	blk_t             x_q;
	blk_t             z_q;
	blk_t             v_q;
	logic             out_valid_q;
	blk_t             out_data_q;

	blk_t      y_base;
	blk_t      x_cur;
	gf_state_t st_cur;
	gf_state_t st_next;
	logic      out_free;
	logic      last;
	logic      finish;
	logic      load_out;
	logic      advance;
	blk_t      out_next;

	always_comb begin
		y_base     = q_entry.start ? '0 : y_q;
		out_free   = !out_valid_q || m_axis_tready;
		st_cur.z   = busy_q ? z_q : '0;
		st_cur.v   = busy_q ? v_q : subkey;
		x_cur      = busy_q ? x_q : (y_base ^ q_entry.blk);
		st_next    = gf_digit(st_cur, x_cur[BLOCK_W-1 -: DIGIT_W]);
		last       = busy_q && (cnt_q == CNT_W'(NUM_DIGITS - 1));
		// an item with no bytes only needs the output slot
		q_pop      = !busy_q && q_valid && (q_entry.absorb || out_free);
		finish     = last && out_free;
		load_out   = finish || (q_pop && !q_entry.absorb);
		out_next   = finish ? st_next.z : y_base;
		advance    = (busy_q && !last) || (q_pop && q_entry.absorb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			y_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop && q_entry.absorb) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(1);
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (finish) begin
				y_q <= st_next.z;
			end else if (q_pop) begin
				y_q <= y_base;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			z_q <= st_next.z;
			v_q <= st_next.v;
			x_q <= x_cur << DIGIT_W;
		end
		if (load_out) begin
			out_data_q <= out_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	// upper half of Y goes out in the low tdata bits
	assign m_axis_tdata  = {out_data_q[HALF_W-1:0], out_data_q[BLOCK_W-1:HALF_W]};

	as_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !busy_q)
		else $error("queue popped while multiply in flight");
	as_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0))
		else $error("digit counter zero while busy");
	as_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> !busy_q && (y_q == out_data_q) && out_valid_q)
		else $error("result not committed on finish");
	as_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("output overwritten before it was taken");

endmodule

// File: design/ghash_accumulator_unit.sv
// GHASH accumulator for GCM. Each input item carries one 128-bit block (tdata) and a start
// flag (tuser) that clears the running hash first; bytes past byte_count are zeroed and a
// count of zero leaves the hash untouched. Every item yields one item holding the updated
// hash Y = (Y xor X) * H. The GF(2^128) multiply is digit serial, 8 bits per cycle, and its
// last digit waits for a free output register. An item with a nonzero count holds the
// multiplier until its result is written out; zero-count items skip it. Up to QUEUE_DEPTH
// items are accepted ahead of the multiplier, and a finished item waits in the output
// register while the next multiply runs. Write subkey H only while no item is in flight.
module ghash_accumulator_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ghacc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ghacc_pkg::HALF_W-1:0]      cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// block_high [63:0], block_low [127:64], byte_count [132:128], zero [135:133]
	input  logic [ghacc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// start_req [0]
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// digest_high [63:0], digest_low [127:64]
	output logic [ghacc_pkg::BLOCK_W-1:0]     m_axis_tdata
);
	import ghacc_pkg::*;

	logic [HALF_W-1:0] subkey_high_q;
	logic [HALF_W-1:0] subkey_low_q;
	ghacc_entry_t      front_entry;
	ghacc_entry_t      q_entry;
	logic              q_full;
	logic              q_empty;
	logic              q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subkey_high_q <= '0;
			subkey_low_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SUBKEY_HIGH: subkey_high_q <= cfg_data;
				REG_SUBKEY_LOW:  subkey_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	ghacc_front u_front (
		.start_req  (s_axis_tuser),
		.block_high (s_axis_tdata[HALF_W-1:0]),
		.block_low  (s_axis_tdata[BLOCK_W-1:HALF_W]),
		.byte_count (s_axis_tdata[BLOCK_W +: COUNT_W]),
		.entry      (front_entry)
	);

	assign s_axis_tready = !q_full;

	ghacc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s_axis_tvalid),
		.wr_entry (front_entry),
		.pop      (q_pop),
		.rd_entry (q_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	ghacc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.subkey        ({subkey_high_q, subkey_low_q}),
		.q_valid       (!q_empty),
		.q_entry       (q_entry),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
